// File: rtl/core/fnks_pkg.sv
// ----------------------------------------------------------------------------
// fnks_pkg
// Shared types and constants of the nearest-K range query selector.
// ----------------------------------------------------------------------------
package fnks_pkg;

    localparam int MAX_SLOTS  = 16;
    localparam int SLOT_W     = $clog2(MAX_SLOTS);
    localparam int FILL_W     = $clog2(MAX_SLOTS + 1);
    localparam int ID_W       = 10;
    localparam int POS_W      = 24;
    localparam int DIST_W     = 50;
    localparam int RSQ_W      = 48;
    localparam int CNT_W      = 16;
    localparam int S_DATA_W   = 128;
    localparam int M_DATA_W   = 176;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_CAND  = 2'd1,
        OP_END   = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INCLUDE_SELF  = 3'd0,
        REG_REQUIRE_ALIVE = 3'd1,
        REG_REQUIRED_TEAM = 3'd2,
        REG_EXCLUDED_TEAM = 3'd3,
        REG_REQUIRED_TYPE = 3'd4,
        REG_MAX_RESULTS   = 3'd5
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST1,
        ST_DIST2,
        ST_FILTER,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_REPLACE,
        ST_STREAM,
        ST_EMIT_RD,
        ST_EMIT,
        ST_SUMMARY
    } state_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [ID_W-1:0]   wid;
        logic [DIST_W-1:0] wdist;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } slot_req_t;

    typedef struct packed {
        logic [ID_W-1:0]   rid;
        logic [DIST_W-1:0] rdist;
    } slot_rsp_t;

endpackage

// File: rtl/core/filtered_nearest_k_selector_unit.sv
// ----------------------------------------------------------------------------
// filtered_nearest_k_selector_unit
// Range query engine keeping the nearest K candidates of each query.
// ----------------------------------------------------------------------------
// Usage: the s_ channel carries start, candidate and end words. A start word
// latches center, radius and owner and clears the slots and counts. Each
// candidate is distance checked, filtered (self, dead, team, type) and then
// streamed out at once (max_results 0) or kept in up to 16 slots, replacing
// the first farthest slot when strictly nearer. An end word emits the kept
// slots in slot order, then one summary word with tlast high.
// Flow: a candidate passes the distance states DIST1 and DIST2 to its FILTER
// decision; a full slot set adds a farthest-slot scan, one slot memory read
// per cycle. An end word reads and emits each kept slot in turn (EMIT_RD,
// EMIT), then the summary; a stalled output holds the emit and the summary.
// One word is in work at a time; s_tready is low meanwhile.
// The cfg channel is always ready. Reset (aresetn low, synchronous) returns
// registers to their defaults and empties the query. A stalled m_ receiver
// holds the output register and the engine waits on it.
// ----------------------------------------------------------------------------
module filtered_nearest_k_selector_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode, agent_id, pos_x, pos_y, pos_z, radius, alive, team_id, obj_type,
    // owner_valid, zero fill
    input  logic [127:0] s_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_id, dist_sq, raw_count, passed_count, result_count,
    // rejected_self, rejected_team, rejected_dead, rejected_type, zero fill
    output logic [175:0] m_tdata,
    // kind
    output logic        m_tuser,
    output logic        m_tlast
);
    import fnks_pkg::*;

    // configuration registers
    logic              inc_self_reg, req_alive_reg;
    logic [8:0]        req_team_reg, exc_team_reg;
    logic [7:0]        req_type_reg;
    logic [4:0]        max_res_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inc_self_reg  <= 1'b0;
            req_alive_reg <= 1'b0;
            req_team_reg  <= '1;
            exc_team_reg  <= '1;
            req_type_reg  <= '0;
            max_res_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_INCLUDE_SELF:  inc_self_reg  <= cfg_data[0];
                REG_REQUIRE_ALIVE: req_alive_reg <= cfg_data[0];
                REG_REQUIRED_TEAM: req_team_reg  <= cfg_data;
                REG_EXCLUDED_TEAM: exc_team_reg  <= cfg_data;
                REG_REQUIRED_TYPE: req_type_reg  <= cfg_data[7:0];
                REG_MAX_RESULTS:   max_res_reg   <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // input field split
    opcode_t            in_op;
    logic [ID_W-1:0]    in_id;
    logic signed [POS_W-1:0] in_x, in_y, in_z;
    logic [23:0]        in_rad;
    logic               in_alive, in_ownv;
    logic [7:0]         in_team, in_type;
    assign in_op    = opcode_t'(s_tdata[1:0]);
    assign in_id    = s_tdata[11:2];
    assign in_x     = s_tdata[35:12];
    assign in_y     = s_tdata[59:36];
    assign in_z     = s_tdata[83:60];
    assign in_rad   = s_tdata[107:84];
    assign in_alive = s_tdata[108];
    assign in_team  = s_tdata[116:109];
    assign in_type  = s_tdata[124:117];
    assign in_ownv  = s_tdata[125];

    // state
    state_t state_reg, state_next;
    logic signed [POS_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [RSQ_W-1:0]  rsq_reg;
    logic [ID_W-1:0]   owner_reg;
    logic              ownp_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [CNT_W-1:0]  c_raw_reg, c_pass_reg, c_res_reg, c_self_reg;
    logic [CNT_W-1:0]  c_team_reg, c_dead_reg, c_type_reg;
    logic [ID_W-1:0]   cid_reg;
    logic              calive_reg;
    logic [7:0]        cteam_reg, ctype_reg;
    logic signed [POS_W:0] dx_reg, dy_reg, dz_reg;
    logic [DIST_W-1:0] sq_x_reg, sq_y_reg, sq_z_reg, dist_reg;
    logic [FILL_W-1:0] idx_reg;
    logic [SLOT_W-1:0] far_reg;
    logic [DIST_W-1:0] far_d_reg;
    logic              mval_reg, mkind_reg;
    logic [M_DATA_W-1:0] mdata_reg;
    logic [23:0]       rad_reg;
    logic              rsq_ld_reg;

    slot_req_t ram_req;
    slot_rsp_t ram_rsp;

    fnks_slot_ram u_ram (
        .aclk (aclk),
        .req  (ram_req),
        .rsp  (ram_rsp)
    );

    logic [FILL_W-1:0] k_eff;
    assign k_eff = (max_res_reg > 5'(MAX_SLOTS)) ? FILL_W'(MAX_SLOTS) : FILL_W'(max_res_reg);

    logic out_free;
    assign out_free = !mval_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    logic acc;
    assign acc = s_tvalid && s_tready;

    // output register load
    logic m_load;
    assign m_load = out_free &&
                    (state_reg == ST_STREAM || state_reg == ST_EMIT ||
                     state_reg == ST_SUMMARY);

    // filter outcome
    logic in_range, rej_self, rej_dead, rej_team, rej_type;
    always_comb begin
        in_range = (rsq_reg == '0) || (dist_reg <= DIST_W'(rsq_reg));
        rej_self = !inc_self_reg && ownp_reg && (cid_reg == owner_reg);
        rej_dead = req_alive_reg && !calive_reg;
        rej_team = (!req_team_reg[8] && cteam_reg != req_team_reg[7:0]) ||
                   (!exc_team_reg[8] && cteam_reg == exc_team_reg[7:0]);
        rej_type = (req_type_reg != 8'd0) && (ctype_reg != req_type_reg);
    end

    logic passed;
    assign passed = in_range && !rej_self && !rej_dead && !rej_team && !rej_type;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    if (in_op == OP_CAND) begin
                        state_next = ST_DIST1;
                    end else if (in_op == OP_END) begin
                        state_next = (fill_reg == '0) ? ST_SUMMARY : ST_EMIT_RD;
                    end
                end
            end
            ST_DIST1:  state_next = ST_DIST2;
            ST_DIST2:  state_next = ST_FILTER;
            ST_FILTER: begin
                if (!passed) begin
                    state_next = ST_IDLE;
                end else if (max_res_reg == 5'd0) begin
                    state_next = ST_STREAM;
                end else if (fill_reg < k_eff) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (idx_reg == fill_reg) state_next = ST_SCAN_LAST;
            end
            ST_SCAN_LAST: state_next = ST_REPLACE;
            ST_REPLACE:   state_next = ST_IDLE;
            ST_STREAM:    if (out_free) state_next = ST_IDLE;
            ST_EMIT_RD:   state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = (idx_reg + FILL_W'(1) == fill_reg) ? ST_SUMMARY : ST_EMIT_RD;
                end
            end
            ST_SUMMARY: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // memory requests
    always_comb begin
        ram_req       = '0;
        ram_req.wid   = cid_reg;
        ram_req.wdist = dist_reg;
        ram_req.waddr = far_reg;
        ram_req.raddr = idx_reg[SLOT_W-1:0];
        case (state_reg)
            ST_FILTER: begin
                if (passed && max_res_reg != 5'd0 && fill_reg < k_eff) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = fill_reg[SLOT_W-1:0];
                end
                ram_req.re    = 1'b1;
                ram_req.raddr = '0;
            end
            ST_SCAN:    ram_req.re = (idx_reg < fill_reg);
            ST_REPLACE: ram_req.we = (dist_reg < far_d_reg);
            ST_EMIT_RD: ram_req.re = 1'b1;
            default: ;
        endcase
    end

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    logic [CNT_W:0] total;
    assign total = {1'b0, c_res_reg} + (CNT_W+1)'(fill_reg);

    // datapath and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            cx_reg <= '0; cy_reg <= '0; cz_reg <= '0;
            rsq_reg    <= '0;
            rad_reg    <= '0;
            rsq_ld_reg <= 1'b0;
            owner_reg  <= '0;
            ownp_reg   <= 1'b0;
            c_raw_reg <= '0; c_pass_reg <= '0; c_res_reg <= '0; c_self_reg <= '0;
            c_team_reg <= '0; c_dead_reg <= '0; c_type_reg <= '0;
            mval_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            // hold the output word until taken, load a new one when free
            mval_reg <= m_load ? 1'b1 : (m_tready ? 1'b0 : mval_reg);
            // square the radius in the cycle after the start word
            rsq_ld_reg <= acc && (in_op == OP_START);
            if (rsq_ld_reg) rsq_reg <= RSQ_W'(rad_reg * rad_reg);
            case (state_reg)
                ST_IDLE: begin
                    if (acc && in_op == OP_START) begin
                        cx_reg <= in_x; cy_reg <= in_y; cz_reg <= in_z;
                        rad_reg    <= in_rad;
                        owner_reg  <= in_id;
                        ownp_reg   <= in_ownv;
                        fill_reg   <= '0;
                        c_raw_reg <= '0; c_pass_reg <= '0; c_res_reg <= '0;
                        c_self_reg <= '0; c_team_reg <= '0; c_dead_reg <= '0;
                        c_type_reg <= '0;
                    end
                    if (acc && in_op == OP_CAND) begin
                        c_raw_reg <= bump(c_raw_reg);
                    end
                end
                ST_FILTER: begin
                    if (in_range) begin
                        if (rej_self) c_self_reg <= bump(c_self_reg);
                        else if (rej_dead) c_dead_reg <= bump(c_dead_reg);
                        else if (rej_team) c_team_reg <= bump(c_team_reg);
                        else if (rej_type) c_type_reg <= bump(c_type_reg);
                        else c_pass_reg <= bump(c_pass_reg);
                    end
                    if (passed && max_res_reg != 5'd0 && fill_reg < k_eff) begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                end
                ST_STREAM: begin
                    if (out_free) begin
                        c_res_reg <= bump(c_res_reg);
                    end
                end
                ST_SUMMARY: begin
                    if (out_free) begin
                        fill_reg  <= '0;
                        c_raw_reg <= '0; c_pass_reg <= '0; c_res_reg <= '0;
                        c_self_reg <= '0; c_team_reg <= '0; c_dead_reg <= '0;
                        c_type_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload path: distance, scan, output word
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                cid_reg    <= in_id;
                calive_reg <= in_alive;
                cteam_reg  <= in_team;
                ctype_reg  <= in_type;
                dx_reg <= (POS_W+1)'(in_x) - (POS_W+1)'(cx_reg);
                dy_reg <= (POS_W+1)'(in_y) - (POS_W+1)'(cy_reg);
                dz_reg <= (POS_W+1)'(in_z) - (POS_W+1)'(cz_reg);
                idx_reg <= '0;
            end
            ST_DIST1: begin
                sq_x_reg <= DIST_W'(dx_reg * dx_reg);
                sq_y_reg <= DIST_W'(dy_reg * dy_reg);
                sq_z_reg <= DIST_W'(dz_reg * dz_reg);
            end
            ST_DIST2: dist_reg <= sq_x_reg + sq_y_reg + sq_z_reg;
            ST_FILTER: begin
                idx_reg <= FILL_W'(1);
                far_reg <= '0;
            end
            ST_SCAN, ST_SCAN_LAST: begin
                // ram_rsp holds slot idx_reg-1
                if (idx_reg == FILL_W'(1) || ram_rsp.rdist > far_d_reg) begin
                    far_d_reg <= ram_rsp.rdist;
                    far_reg   <= SLOT_W'(idx_reg - 1'b1);
                end
                if (state_reg == ST_SCAN && idx_reg != fill_reg) begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            ST_STREAM: begin
                if (out_free) begin
                    mkind_reg <= 1'b0;
                    mdata_reg <= M_DATA_W'({dist_reg, cid_reg});
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    mkind_reg <= 1'b0;
                    mdata_reg <= M_DATA_W'({ram_rsp.rdist, ram_rsp.rid});
                    idx_reg   <= idx_reg + 1'b1;
                end
            end
            ST_SUMMARY: begin
                if (out_free) begin
                    mkind_reg <= 1'b1;
                    mdata_reg <= M_DATA_W'({c_type_reg, c_dead_reg, c_team_reg, c_self_reg,
                                            total[CNT_W] ? CNT_MAX : total[CNT_W-1:0],
                                            c_pass_reg, c_raw_reg,
                                            {DIST_W{1'b0}}, {ID_W{1'b0}}});
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = mkind_reg;
    assign m_tlast  = mkind_reg;
endmodule

// File: rtl/core/fnks_slot_ram.sv
// ----------------------------------------------------------------------------
// fnks_slot_ram
// Kept-slot store: one write and one registered read port.
// ----------------------------------------------------------------------------
module fnks_slot_ram (
    input  logic               aclk,
    input  fnks_pkg::slot_req_t req,
    output fnks_pkg::slot_rsp_t rsp
);
    import fnks_pkg::*;

    logic [ID_W+DIST_W-1:0] mem [MAX_SLOTS];
    logic [ID_W+DIST_W-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= {req.wid, req.wdist};
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rsp.rid   = rdata_reg[ID_W+DIST_W-1:DIST_W];
    assign rsp.rdist = rdata_reg[DIST_W-1:0];
endmodule
